// File: hdl/lslf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_pkg: shared types and constants of the 3D least-squares line fit
// Payload widths, operand codes, job numbers and the controller/datapath
// command, status and result structs.
// ----------------------------------------------------------------------------
package lslf_pkg;

	// fixed payload widths
	localparam int IN_W  = 24;
	localparam int OUT_W = 48;

	// parameter defaults
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 16;

	// job numbering of the solve sequence
	localparam int JOB_W        = 4;
	localparam int JOB_LAST_MUL = 9;
	localparam int JOB_IERR     = 4;
	localparam int JOB_SERR     = 5;

	// derived widths
	function automatic int cnt_w(input int maxp);
		return $clog2(maxp + 1);
	endfunction

	function automatic int sq_w(input int maxp, input int cw);
		return 2 * cw + cnt_w(maxp);
	endfunction

	function automatic int num_w(input int maxp, input int cw);
		return 3 * cw + 2 * cnt_w(maxp);
	endfunction

	function automatic int dv_w(input int maxp, input int cw, input int fb);
		int a;
		int b;
		a = num_w(maxp, cw) + fb;
		b = sq_w(maxp, cw) + 2 * fb;
		return (a > b) ? a : b;
	endfunction

	function automatic int rt_w(input int maxp, input int cw, input int fb);
		return (dv_w(maxp, cw, fb) + 1) / 2;
	endfunction

	// operand select of the serial multiplier
	typedef enum logic [2:0] {
		OP_N,
		OP_SZ,
		OP_SX,
		OP_SY,
		OP_SZZ,
		OP_SXZ,
		OP_SYZ
	} op_t;

	typedef struct packed {
		logic             capture;
		logic             prod;
		logic             acc;
		logic             mul_load;
		logic             mul_step;
		logic             mul_clear;
		logic             mul_sub;
		op_t              a_sel;
		op_t              b_sel;
		logic             num_store;
		logic             check;
		logic             div_load;
		logic             div_step;
		logic             sqrt_load;
		logic             sqrt_step;
		logic             res_store;
		logic             out_load;
		logic [JOB_W-1:0] job;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic den_pos;
	} sts_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] intercept_x;
		logic signed [OUT_W-1:0] slope_x;
		logic signed [OUT_W-1:0] intercept_y;
		logic signed [OUT_W-1:0] slope_y;
		logic        [OUT_W-1:0] intercept_error;
		logic        [OUT_W-1:0] slope_error;
		logic                    degenerate;
		logic                    overflowed;
	} res_t;

endpackage
`default_nettype wire

// File: hdl/lslf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_if: valid/ready channels of the line fit
// Point channel and fit result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface lslf_in_if;
	logic                        valid;
	logic                        ready;
	logic [lslf_pkg::IN_W-1:0]   point_x;
	logic [lslf_pkg::IN_W-1:0]   point_y;
	logic [lslf_pkg::IN_W-1:0]   point_z;
	logic                        last_point;

	modport source (output valid, output point_x, output point_y, output point_z,
		output last_point, input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		input last_point, output ready);
endinterface

interface lslf_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [lslf_pkg::OUT_W-1:0]  intercept_x;
	logic signed [lslf_pkg::OUT_W-1:0]  slope_x;
	logic signed [lslf_pkg::OUT_W-1:0]  intercept_y;
	logic signed [lslf_pkg::OUT_W-1:0]  slope_y;
	logic        [lslf_pkg::OUT_W-1:0]  intercept_error;
	logic        [lslf_pkg::OUT_W-1:0]  slope_error;
	logic                               degenerate;
	logic                               overflowed;

	modport source (output valid, output intercept_x, output slope_x,
		output intercept_y, output slope_y, output intercept_error,
		output slope_error, output degenerate, output overflowed, input ready);
	modport sink (input valid, input intercept_x, input slope_x,
		input intercept_y, input slope_y, input intercept_error,
		input slope_error, input degenerate, input overflowed, output ready);
endinterface
`default_nettype wire

// File: hdl/lslf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_dp: line fit datapath
// Running sums, a bit-serial multiply-accumulate, a restoring divider, a
// digit-by-digit square root and the result registers.
// ----------------------------------------------------------------------------
module lslf_dp #(
	parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = lslf_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = lslf_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [lslf_pkg::IN_W-1:0] px,
	input  logic [lslf_pkg::IN_W-1:0] py,
	input  logic [lslf_pkg::IN_W-1:0] pz,
	input  logic                      plast,
	input  lslf_pkg::cmd_t            cmd,
	output lslf_pkg::sts_t            sts,
	output lslf_pkg::res_t            fit
);

	localparam int OUT_W = lslf_pkg::OUT_W;
	localparam int IN_W  = lslf_pkg::IN_W;
	localparam int CW    = COORD_BITS;
	localparam int NW    = lslf_pkg::cnt_w(MAX_POINTS);
	localparam int S1W   = CW + NW;
	localparam int PW    = 2 * CW;
	localparam int SQW   = lslf_pkg::sq_w(MAX_POINTS, CW);
	localparam int NUMW  = lslf_pkg::num_w(MAX_POINTS, CW);
	localparam int DVW   = lslf_pkg::dv_w(MAX_POINTS, CW, FRAC_BITS);
	localparam int RTW   = lslf_pkg::rt_w(MAX_POINTS, CW, FRAC_BITS);
	localparam int QEW   = ((DVW > OUT_W) ? DVW : OUT_W) + 1;
	localparam int REW   = ((RTW > OUT_W) ? RTW : OUT_W) + 1;

	localparam logic [OUT_W-1:0] SMAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] SMIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [OUT_W-1:0] UMAX = {OUT_W{1'b1}};

	// point pipeline
	logic [IN_W+CW-1:0]    ex, ey, ez;
	logic signed [CW-1:0]  x_s1, y_s1, z_s1;
	logic                  last_s1;
	logic signed [PW-1:0]  zz_s2, xz_s2, yz_s2;

	// running sums
	logic signed [S1W-1:0] sz_q, sx_q, sy_q;
	logic signed [SQW-1:0] szz_q, sxz_q, syz_q;
	logic [NW-1:0]         cnt_q;
	logic                  drop_q;

	// multiplier
	logic signed [SQW-1:0]  a_val, b_val;
	logic signed [NUMW-1:0] acc_q, ash_q;
	logic [SQW-1:0]         bmag_q;
	logic                   mneg_q;
	logic signed [NUMW-1:0] den_q;
	logic signed [NUMW-1:0] num_q [4];

	// divider
	logic signed [NUMW-1:0] num_sel;
	logic [NUMW-1:0]        num_mag;
	logic [DVW-1:0]         nq_q;
	logic [NUMW-1:0]        rem_q;
	logic                   qneg_q;
	logic [NUMW:0]          dtrial, dden;
	logic                   dge;

	// square root
	logic [2*RTW-1:0]       sv_q;
	logic [RTW+1:0]         srem_q;
	logic [RTW-1:0]         root_q;
	logic [RTW+3:0]         r4, strial;
	logic                   sge;

	// results
	logic [QEW-1:0]         qx, qx_neg;
	logic [REW-1:0]         rx;
	logic [OUT_W-1:0]       qsat, rsat;
	logic [OUT_W-1:0]       res_q [6];
	logic                   degen_q;
	lslf_pkg::res_t         fit_q;
	logic                   den_pos;

	function automatic logic signed [SQW-1:0] opv(input lslf_pkg::op_t s,
		input logic [NW-1:0] n, input logic signed [S1W-1:0] z,
		input logic signed [S1W-1:0] x, input logic signed [S1W-1:0] y,
		input logic signed [SQW-1:0] zz, input logic signed [SQW-1:0] xz,
		input logic signed [SQW-1:0] yz);
		logic signed [SQW-1:0] v;
		case (s)
			lslf_pkg::OP_N:   v = SQW'($signed({1'b0, n}));
			lslf_pkg::OP_SZ:  v = SQW'(z);
			lslf_pkg::OP_SX:  v = SQW'(x);
			lslf_pkg::OP_SY:  v = SQW'(y);
			lslf_pkg::OP_SZZ: v = zz;
			lslf_pkg::OP_SXZ: v = xz;
			lslf_pkg::OP_SYZ: v = yz;
			default:          v = '0;
		endcase
		return v;
	endfunction

	// coordinate fields: low COORD_BITS bits as two's complement
	assign ex = (IN_W+CW)'(px);
	assign ey = (IN_W+CW)'(py);
	assign ez = (IN_W+CW)'(pz);

	// point capture and products
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_s1    <= ex[CW-1:0];
			y_s1    <= ey[CW-1:0];
			z_s1    <= ez[CW-1:0];
			last_s1 <= plast;
		end
		if (cmd.prod) begin
			zz_s2 <= z_s1 * z_s1;
			xz_s2 <= x_s1 * z_s1;
			yz_s2 <= y_s1 * z_s1;
		end
	end

	// running sums, cleared when the result is handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sz_q   <= '0;
			sx_q   <= '0;
			sy_q   <= '0;
			szz_q  <= '0;
			sxz_q  <= '0;
			syz_q  <= '0;
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (cmd.out_load) begin
			sz_q   <= '0;
			sx_q   <= '0;
			sy_q   <= '0;
			szz_q  <= '0;
			sxz_q  <= '0;
			syz_q  <= '0;
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (cmd.acc) begin
			if (cnt_q < NW'(MAX_POINTS)) begin
				sz_q  <= sz_q + S1W'(z_s1);
				sx_q  <= sx_q + S1W'(x_s1);
				sy_q  <= sy_q + S1W'(y_s1);
				szz_q <= szz_q + SQW'(zz_s2);
				sxz_q <= sxz_q + SQW'(xz_s2);
				syz_q <= syz_q + SQW'(yz_s2);
				cnt_q <= cnt_q + NW'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	assign a_val = opv(cmd.a_sel, cnt_q, sz_q, sx_q, sy_q, szz_q, sxz_q, syz_q);
	assign b_val = opv(cmd.b_sel, cnt_q, sz_q, sx_q, sy_q, szz_q, sxz_q, syz_q);

	// serial multiply-accumulate, one bit of |b| per step
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			ash_q  <= NUMW'(a_val);
			bmag_q <= b_val[SQW-1] ? SQW'(-b_val) : SQW'(b_val);
			mneg_q <= b_val[SQW-1] ^ cmd.mul_sub;
			if (cmd.mul_clear) begin
				acc_q <= '0;
			end
		end else if (cmd.mul_step) begin
			if (bmag_q[0]) begin
				acc_q <= mneg_q ? acc_q - ash_q : acc_q + ash_q;
			end
			ash_q  <= ash_q <<< 1;
			bmag_q <= bmag_q >> 1;
		end
		if (cmd.num_store) begin
			if (cmd.job[lslf_pkg::JOB_W-1:1] == '0) begin
				den_q <= acc_q;
			end else begin
				num_q[2'(cmd.job[lslf_pkg::JOB_W-1:1] - 3'd1)] <= acc_q;
			end
		end
	end

	assign den_pos = !den_q[NUMW-1] && (den_q != '0);

	// divider operand
	always_comb begin
		num_sel = num_q[cmd.job[1:0]];
		num_mag = num_sel[NUMW-1] ? NUMW'(-num_sel) : NUMW'(num_sel);
	end

	assign dden   = {1'b0, den_q};
	assign dtrial = {rem_q, nq_q[DVW-1]};
	assign dge    = dtrial >= dden;

	// restoring divider, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			if (cmd.job == lslf_pkg::JOB_W'(lslf_pkg::JOB_IERR)) begin
				nq_q   <= DVW'($unsigned(szz_q)) << (2 * FRAC_BITS);
				qneg_q <= 1'b0;
			end else if (cmd.job == lslf_pkg::JOB_W'(lslf_pkg::JOB_SERR)) begin
				nq_q   <= DVW'(cnt_q) << (2 * FRAC_BITS);
				qneg_q <= 1'b0;
			end else begin
				nq_q   <= DVW'(num_mag) << FRAC_BITS;
				qneg_q <= num_sel[NUMW-1];
			end
		end else if (cmd.div_step) begin
			rem_q <= dge ? NUMW'(dtrial - dden) : dtrial[NUMW-1:0];
			nq_q  <= {nq_q[DVW-2:0], dge};
		end
	end

	assign r4     = {srem_q, sv_q[2*RTW-1 -: 2]};
	assign strial = (RTW+4)'({root_q, 2'b01});
	assign sge    = r4 >= strial;

	// square root, one root bit per step
	always_ff @(posedge clk) begin
		if (cmd.sqrt_load) begin
			sv_q   <= (2*RTW)'(nq_q);
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			srem_q <= sge ? (RTW+2)'(r4 - strial) : r4[RTW+1:0];
			root_q <= {root_q[RTW-2:0], sge};
			sv_q   <= sv_q << 2;
		end
	end

	// saturation to the output ranges
	always_comb begin
		qx     = QEW'(nq_q);
		qx_neg = -qx;
		if (!qneg_q) begin
			qsat = (qx > QEW'(SMAX)) ? SMAX : qx[OUT_W-1:0];
		end else begin
			qsat = (qx > QEW'(SMIN)) ? SMIN : qx_neg[OUT_W-1:0];
		end
		rx   = REW'(root_q);
		rsat = (rx > REW'(UMAX)) ? UMAX : rx[OUT_W-1:0];
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			degen_q <= !den_pos;
			if (!den_pos) begin
				for (int i = 0; i < 6; i++) begin
					res_q[i] <= '0;
				end
			end
		end
		if (cmd.res_store) begin
			if (cmd.job < lslf_pkg::JOB_W'(lslf_pkg::JOB_IERR)) begin
				res_q[cmd.job[2:0]] <= qsat;
			end else begin
				res_q[cmd.job[2:0]] <= rsat;
			end
		end
		if (cmd.out_load) begin
			fit_q.intercept_x     <= res_q[0];
			fit_q.slope_x         <= res_q[1];
			fit_q.intercept_y     <= res_q[2];
			fit_q.slope_y         <= res_q[3];
			fit_q.intercept_error <= res_q[4];
			fit_q.slope_error     <= res_q[5];
			fit_q.degenerate      <= degen_q;
			fit_q.overflowed      <= drop_q;
		end
	end

	assign fit         = fit_q;
	assign sts.last    = last_s1;
	assign sts.den_pos = den_pos;

endmodule
`default_nettype wire

// File: hdl/lslf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslf_ctrl: line fit controller
// Sequences point accumulation, the ten products, the six divisions and the
// two square roots, and owns the result valid.
// ----------------------------------------------------------------------------
module lslf_ctrl #(
	parameter int MUL_STEPS  = lslf_pkg::sq_w(lslf_pkg::MAX_POINTS_DEF,
		lslf_pkg::COORD_BITS_DEF),
	parameter int DIV_STEPS  = lslf_pkg::dv_w(lslf_pkg::MAX_POINTS_DEF,
		lslf_pkg::COORD_BITS_DEF, lslf_pkg::FRAC_BITS_DEF),
	parameter int SQRT_STEPS = lslf_pkg::rt_w(lslf_pkg::MAX_POINTS_DEF,
		lslf_pkg::COORD_BITS_DEF, lslf_pkg::FRAC_BITS_DEF)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output lslf_pkg::cmd_t cmd,
	input  lslf_pkg::sts_t sts
);

	localparam int JOB_W = lslf_pkg::JOB_W;
	localparam int SW    = $clog2(DIV_STEPS + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PROD,
		S_ACC,
		S_MLOAD,
		S_MRUN,
		S_MEND,
		S_CHECK,
		S_DLOAD,
		S_DRUN,
		S_DEND,
		S_SLOAD,
		S_SRUN,
		S_SEND,
		S_DONE
	} state_t;

	typedef struct packed {
		lslf_pkg::op_t a;
		lslf_pkg::op_t b;
	} mulop_t;

	state_t           state_q;
	logic [JOB_W-1:0] job_q;
	logic [SW-1:0]    step_q;
	logic             out_valid_q;
	mulop_t           mop;

	// product list: den, then numerators of ax, bx, ay, by, two terms each
	function automatic mulop_t mul_ops(input logic [JOB_W-1:0] j);
		mulop_t m;
		case (j)
			4'd0:    m = '{lslf_pkg::OP_N,   lslf_pkg::OP_SZZ};
			4'd1:    m = '{lslf_pkg::OP_SZ,  lslf_pkg::OP_SZ};
			4'd2:    m = '{lslf_pkg::OP_SZZ, lslf_pkg::OP_SX};
			4'd3:    m = '{lslf_pkg::OP_SXZ, lslf_pkg::OP_SZ};
			4'd4:    m = '{lslf_pkg::OP_N,   lslf_pkg::OP_SXZ};
			4'd5:    m = '{lslf_pkg::OP_SX,  lslf_pkg::OP_SZ};
			4'd6:    m = '{lslf_pkg::OP_SZZ, lslf_pkg::OP_SY};
			4'd7:    m = '{lslf_pkg::OP_SYZ, lslf_pkg::OP_SZ};
			4'd8:    m = '{lslf_pkg::OP_N,   lslf_pkg::OP_SYZ};
			4'd9:    m = '{lslf_pkg::OP_SY,  lslf_pkg::OP_SZ};
			default: m = '{lslf_pkg::OP_N,   lslf_pkg::OP_N};
		endcase
		return m;
	endfunction

	assign mop      = mul_ops(job_q);
	assign in_ready = (state_q == S_IDLE);

	// commands decoded from state
	always_comb begin
		cmd       = '0;
		cmd.job   = job_q;
		cmd.a_sel = mop.a;
		cmd.b_sel = mop.b;
		case (state_q)
			S_IDLE:  cmd.capture   = in_valid;
			S_PROD:  cmd.prod      = 1'b1;
			S_ACC:   cmd.acc       = 1'b1;
			S_MLOAD: begin
				cmd.mul_load  = 1'b1;
				cmd.mul_sub   = job_q[0];
				cmd.mul_clear = !job_q[0];
			end
			S_MRUN:  cmd.mul_step  = 1'b1;
			S_MEND:  cmd.num_store = job_q[0];
			S_CHECK: cmd.check     = 1'b1;
			S_DLOAD: cmd.div_load  = 1'b1;
			S_DRUN:  cmd.div_step  = 1'b1;
			S_DEND:  cmd.res_store = (job_q < JOB_W'(lslf_pkg::JOB_IERR));
			S_SLOAD: cmd.sqrt_load = 1'b1;
			S_SRUN:  cmd.sqrt_step = 1'b1;
			S_SEND:  cmd.res_store = 1'b1;
			S_DONE:  cmd.out_load  = !out_valid_q || out_ready;
			default: cmd.job       = job_q;
		endcase
	end

	// state, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_PROD;
				end
				S_PROD: state_q <= S_ACC;
				S_ACC: begin
					job_q   <= '0;
					state_q <= sts.last ? S_MLOAD : S_IDLE;
				end
				S_MLOAD: begin
					step_q  <= '0;
					state_q <= S_MRUN;
				end
				S_MRUN: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(MUL_STEPS - 1)) state_q <= S_MEND;
				end
				S_MEND: begin
					if (job_q == JOB_W'(lslf_pkg::JOB_LAST_MUL)) begin
						state_q <= S_CHECK;
					end else begin
						job_q   <= job_q + JOB_W'(1);
						state_q <= S_MLOAD;
					end
				end
				S_CHECK: begin
					job_q   <= '0;
					state_q <= sts.den_pos ? S_DLOAD : S_DONE;
				end
				S_DLOAD: begin
					step_q  <= '0;
					state_q <= S_DRUN;
				end
				S_DRUN: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(DIV_STEPS - 1)) state_q <= S_DEND;
				end
				S_DEND: begin
					if (job_q >= JOB_W'(lslf_pkg::JOB_IERR)) begin
						state_q <= S_SLOAD;
					end else begin
						job_q   <= job_q + JOB_W'(1);
						state_q <= S_DLOAD;
					end
				end
				S_SLOAD: begin
					step_q  <= '0;
					state_q <= S_SRUN;
				end
				S_SRUN: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(SQRT_STEPS - 1)) state_q <= S_SEND;
				end
				S_SEND: begin
					if (job_q == JOB_W'(lslf_pkg::JOB_SERR)) begin
						state_q <= S_DONE;
					end else begin
						job_q   <= job_q + JOB_W'(1);
						state_q <= S_DLOAD;
					end
				end
				S_DONE: begin
					if (cmd.out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// accepted point always moves on to the product stage
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_PROD))
		else $error("accepted point did not enter product stage");

	// result register is only loaded when free or being drained
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

	// multiplier iteration counter stays within its length
	a_mul_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MRUN) |-> (step_q < SW'(MUL_STEPS)))
		else $error("multiplier ran past its length");

	// no new point while the multiplier or divider is running
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRUN || state_q == S_MRUN) |-> !in_ready)
		else $error("point channel open during solve");

endmodule
`default_nettype wire

// File: hdl/least_squares_line_fit_3d.sv
`default_nettype none
// ----------------------------------------------------------------------------
// least_squares_line_fit_3d: least-squares fit of x(z) and y(z) to 3D points
// Accumulates point sums, solves on the marked last point and returns
// intercepts, slopes and parameter errors in Q(FRAC_BITS).
//
//   channel    dir   handshake      payload
//   point_in   in    valid/ready    point_x, point_y, point_z, last_point
//   fit_out    out   valid/ready    intercepts, slopes, errors, flags
//
// A point passes capture, products and accumulate in turn, one point at a time.
// The solve on a last point runs ten multiplications and, unless degenerate,
// six divisions and two square roots; M = 2*COORD_BITS+clog2(MAX_POINTS+1)
// bits of the serial multiplier, D the quotient bits of the restoring divider
// and R = (D+1)/2 root bits, each unit taking one bit per step.
// Reset clears sums and control at once; no clearing pass.
// A waiting result does not block accumulation of the next point set.
// ----------------------------------------------------------------------------
module least_squares_line_fit_3d #(
	parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = lslf_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = lslf_pkg::FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	lslf_in_if.sink    point_in,
	lslf_out_if.source fit_out
);

	localparam int MUL_STEPS  = lslf_pkg::sq_w(MAX_POINTS, COORD_BITS);
	localparam int DIV_STEPS  = lslf_pkg::dv_w(MAX_POINTS, COORD_BITS, FRAC_BITS);
	localparam int SQRT_STEPS = lslf_pkg::rt_w(MAX_POINTS, COORD_BITS, FRAC_BITS);

	lslf_pkg::cmd_t cmd;
	lslf_pkg::sts_t sts;
	lslf_pkg::res_t fit;
	logic           in_ready;
	logic           out_valid;

	// sequencing
	lslf_ctrl #(
		.MUL_STEPS  (MUL_STEPS),
		.DIV_STEPS  (DIV_STEPS),
		.SQRT_STEPS (SQRT_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point_in.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (fit_out.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// arithmetic
	lslf_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.px     (point_in.point_x),
		.py     (point_in.point_y),
		.pz     (point_in.point_z),
		.plast  (point_in.last_point),
		.cmd    (cmd),
		.sts    (sts),
		.fit    (fit)
	);

	// channel hookup
	assign point_in.ready          = in_ready;
	assign fit_out.valid           = out_valid;
	assign fit_out.intercept_x     = fit.intercept_x;
	assign fit_out.slope_x         = fit.slope_x;
	assign fit_out.intercept_y     = fit.intercept_y;
	assign fit_out.slope_y         = fit.slope_y;
	assign fit_out.intercept_error = fit.intercept_error;
	assign fit_out.slope_error     = fit.slope_error;
	assign fit_out.degenerate      = fit.degenerate;
	assign fit_out.overflowed      = fit.overflowed;

endmodule
`default_nettype wire

// File: tb/tb_fit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fit_checker: line fit prediction and result comparison
// Watches accepted points, keeps its own running sums, solves each point set
// at the marked last point with wide integer math and checks every fit result
// field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_fit_checker (
	input logic      clk,
	input logic      arst_n,
	lslf_in_if.sink  point_mon,
	lslf_out_if.sink fit_mon,
	output int       fail_count,
	output int       pending_fits
);

	localparam int MAXP  = lslf_pkg::MAX_POINTS_DEF;
	localparam int FB    = lslf_pkg::FRAC_BITS_DEF;
	localparam int OUT_W = lslf_pkg::OUT_W;

	typedef logic signed [255:0] big_t;

	// running sums of the open point set
	int              set_count;
	big_t            acc_z, acc_x, acc_y, acc_zz, acc_xz, acc_yz;
	logic            set_dropped;
	lslf_pkg::res_t  fit_queue[$];

	// signed quotient with truncation toward zero, clamped to 48 bits
	function automatic logic [OUT_W-1:0] clamp_quot(input big_t num, input big_t den);
		big_t q;
		big_t mag;
		mag = (num < 0) ? -num : num;
		q = mag / den;
		if (num < 0)
			q = -q;
		if (q > big_t'(64'sd140737488355327))
			q = big_t'(64'sd140737488355327);
		else if (q < -big_t'(64'sd140737488355328))
			q = -big_t'(64'sd140737488355328);
		return q[OUT_W-1:0];
	endfunction

	// floor square root of floor(v * 2^(2*FB) / den), clamped to 48 bits
	function automatic logic [OUT_W-1:0] root_err(input big_t v, input big_t den);
		logic [255:0] quot;
		logic [255:0] root;
		logic [255:0] trial;
		quot = (v <<< (2 * FB)) / den;
		root = '0;
		for (int b = 127; b >= 0; b--) begin
			trial = root | (256'd1 << b);
			if (trial * trial <= quot)
				root = trial;
		end
		if (root > 256'hFFFFFFFFFFFF)
			root = 256'hFFFFFFFFFFFF;
		return root[OUT_W-1:0];
	endfunction

	function automatic lslf_pkg::res_t solve_set();
		lslf_pkg::res_t r;
		big_t n, den;
		r = '0;
		n = set_count;
		den = n * acc_zz - acc_z * acc_z;
		if (den <= 0) begin
			r.degenerate = 1'b1;
		end else begin
			r.intercept_x = clamp_quot((acc_zz * acc_x - acc_xz * acc_z) <<< FB, den);
			r.slope_x = clamp_quot((n * acc_xz - acc_x * acc_z) <<< FB, den);
			r.intercept_y = clamp_quot((acc_zz * acc_y - acc_yz * acc_z) <<< FB, den);
			r.slope_y = clamp_quot((n * acc_yz - acc_y * acc_z) <<< FB, den);
			r.intercept_error = root_err(acc_zz, den);
			r.slope_error = root_err(n, den);
		end
		r.overflowed = set_dropped;
		return r;
	endfunction

	task automatic report(input string field, input logic [OUT_W-1:0] exp_v,
		input logic [OUT_W-1:0] got_v);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch %s: expected %h actual %h", field, exp_v, got_v);
	endtask

	// prediction on accepted point requests and check of accepted results
	always @(posedge clk or negedge arst_n) begin
		big_t x, y, z;
		lslf_pkg::res_t e;
		if (!arst_n) begin
			set_count = 0;
			acc_z = 0; acc_x = 0; acc_y = 0; acc_zz = 0; acc_xz = 0; acc_yz = 0;
			set_dropped = 1'b0;
			fail_count = 0;
			pending_fits = fit_queue.size();
		end else begin
			if (point_mon.valid && point_mon.ready) begin
				if (set_count < MAXP) begin
					x = $signed(point_mon.point_x);
					y = $signed(point_mon.point_y);
					z = $signed(point_mon.point_z);
					acc_z += z; acc_x += x; acc_y += y;
					acc_zz += z * z; acc_xz += x * z; acc_yz += y * z;
					set_count++;
				end else begin
					set_dropped = 1'b1;
				end
				if (point_mon.last_point) begin
					fit_queue.insert(fit_queue.size(), solve_set());
					set_count = 0;
					acc_z = 0; acc_x = 0; acc_y = 0; acc_zz = 0; acc_xz = 0; acc_yz = 0;
					set_dropped = 1'b0;
				end
			end
			if (fit_mon.valid && fit_mon.ready) begin
				if (fit_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected fit result");
				end else begin
					e = fit_queue.pop_front();
					if (fit_mon.intercept_x !== e.intercept_x)
						report("intercept_x", e.intercept_x, fit_mon.intercept_x);
					if (fit_mon.slope_x !== e.slope_x)
						report("slope_x", e.slope_x, fit_mon.slope_x);
					if (fit_mon.intercept_y !== e.intercept_y)
						report("intercept_y", e.intercept_y, fit_mon.intercept_y);
					if (fit_mon.slope_y !== e.slope_y)
						report("slope_y", e.slope_y, fit_mon.slope_y);
					if (fit_mon.intercept_error !== e.intercept_error)
						report("intercept_error", e.intercept_error, fit_mon.intercept_error);
					if (fit_mon.slope_error !== e.slope_error)
						report("slope_error", e.slope_error, fit_mon.slope_error);
					if (fit_mon.degenerate !== e.degenerate)
						report("degenerate", e.degenerate, fit_mon.degenerate);
					if (fit_mon.overflowed !== e.overflowed)
						report("overflowed", e.overflowed, fit_mon.overflowed);
				end
			end
			pending_fits = fit_queue.size();
		end
	end

	// expectations left over when the run ends are counted by the top
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the 3D least-squares line fit
// Sends directed and random point sets with bursty requests and a stalling
// result side, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int STALL_LIMIT = 20000;
	localparam int MAXP = lslf_pkg::MAX_POINTS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending_fits;
	int   idle_cycles;
	bit   hold_off = 1'b0;
	bit   long_hold_done = 1'b0;

	lslf_in_if  point_ch ();
	lslf_out_if fit_ch ();

	least_squares_line_fit_3d DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.point_in(point_ch.sink),
		.fit_out (fit_ch.source)
	);

	tb_fit_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_mon   (point_ch.sink),
		.fit_mon     (fit_ch.sink),
		.fail_count  (fail_count),
		.pending_fits(pending_fits)
	);

	always #2 clk = ~clk;

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver stall pattern, with one long hold-off
	always @(posedge clk) begin
		if (!arst_n)
			fit_ch.ready <= 1'b0;
		else if (hold_off)
			fit_ch.ready <= 1'b0;
		else
			fit_ch.ready <= ($urandom_range(0, 3) != 0);
	end

	initial begin
		wait (arst_n);
		repeat (3000) @(posedge clk);
		hold_off = 1'b1;
		repeat (6000) @(posedge clk);
		hold_off = 1'b0;
		long_hold_done = 1'b1;
	end

	// watchdog on cycles without any accepted request
	always @(posedge clk) begin
		if ((point_ch.valid && point_ch.ready) || (fit_ch.valid && fit_ch.ready)
			|| !arst_n || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("least_squares_line_fit_3d verification failed");
			$finish;
		end
	end

	int burst_left = 0;

	// one point request, with burst gaps between requests
	task automatic send_point(input logic [23:0] x, input logic [23:0] y,
		input logic [23:0] z, input logic last);
		if (burst_left == 0) begin
			point_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end
		burst_left--;
		point_ch.valid <= 1'b1;
		point_ch.point_x <= x;
		point_ch.point_y <= y;
		point_ch.point_z <= z;
		point_ch.last_point <= last;
		@(posedge clk);
		while (!point_ch.ready)
			@(posedge clk);
	endtask

	function automatic logic [23:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($signed($urandom_range(0, 200)) - 100);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_set(input int npts);
		logic [23:0] ax, bx;
		ax = rnd_coord();
		bx = 24'($signed($urandom_range(0, 40)) - 20);
		for (int i = 0; i < npts; i++) begin
			if ($urandom_range(0, 1))
				send_point(24'(ax + bx * i), rnd_coord(), 24'(i * 7 - 50), i == npts - 1);
			else
				send_point(rnd_coord(), rnd_coord(), rnd_coord(), i == npts - 1);
		end
	endtask

	initial begin
		int sent;
		int n;
		point_ch.valid = 1'b0;
		point_ch.point_x = '0;
		point_ch.point_y = '0;
		point_ch.point_z = '0;
		point_ch.last_point = 1'b0;
		wait (arst_n);
		@(posedge clk);
		// single point, identical z, extremes, exact line
		send_point(24'd5, 24'd6, 24'd7, 1'b1);
		send_point(24'h7FFFFF, 24'h800000, 24'd3, 1'b0);
		send_point(24'h800000, 24'h7FFFFF, 24'd3, 1'b1);
		send_point(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b0);
		send_point(24'h800000, 24'h800000, 24'h7FFFFF, 1'b1);
		send_point(24'd1, 24'd2, 24'd0, 1'b0);
		send_point(24'd3, 24'hFFFFFE, 24'd1, 1'b0);
		send_point(24'd5, 24'hFFFFFA, 24'd2, 1'b1);
		send_point(24'h7FFFFF, 24'h800000, 24'd0, 1'b0);
		send_point(24'h800000, 24'h7FFFFF, 24'd1, 1'b1);
		send_point(24'hFFFFFF, 24'd0, 24'hFFFFFF, 1'b0);
		send_point(24'd0, 24'hFFFFFF, 24'd0, 1'b1);
		// full count: dropped points, last one dropped too
		for (int i = 0; i < MAXP + 3; i++)
			send_point(24'(i * 3), 24'(-i), 24'(i), i == MAXP + 2);
		// sender pause until every result has come
		point_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending_fits == 0);
		sent = 0;
		while (sent < 1900 || !long_hold_done) begin
			n = ($urandom_range(0, 20) == 0) ? $urandom_range(MAXP - 2, MAXP + 4)
				: $urandom_range(1, 8);
			random_set(n);
			sent += n;
		end
		point_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending_fits == 0);
		repeat (2000) @(posedge clk);
		if (fail_count == 0 && pending_fits == 0 && !fit_ch.valid)
			$display("least_squares_line_fit_3d verification clean");
		else
			$display("least_squares_line_fit_3d verification failed");
		$finish;
	end
endmodule

// File: sim.f
hdl/lslf_pkg.sv
hdl/lslf_if.sv
hdl/lslf_dp.sv
hdl/lslf_ctrl.sv
hdl/least_squares_line_fit_3d.sv
tb/tb_fit_checker.sv
tb/tb_top.sv
